>>> rtl/core/hbht_pkg.sv
`default_nettype none

package hbht_pkg;

    localparam int HEIGHT_W      = 64;
    localparam int AMOUNT_W      = 64;
    localparam int ENTRY_COUNT_W = 6;
    localparam int MODE_W        = 2;
    localparam int S_TDATA_W     = HEIGHT_W + AMOUNT_W;
    localparam int M_TDATA_W     = 3 * 64 + ENTRY_COUNT_W + 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD    = 2'd0,
        MODE_PRUNE  = 2'd1,
        MODE_LOOKUP = 2'd2,
        MODE_LIST   = 2'd3
    } mode_t;

    typedef struct packed {
        logic [HEIGHT_W-1:0] height;
        logic [AMOUNT_W-1:0] amount;
    } entry_t;

    typedef struct packed {
        logic lt;
        logic eq;
        logic le;
        logic amt_ge;
        logic amt_eq;
    } cmp_res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_MOVE,
        ST_PUT,
        ST_STAT,
        ST_RESP,
        ST_LREAD,
        ST_LLOAD,
        ST_LWAIT
    } state_t;

endpackage

`default_nettype wire

>>> rtl/core/hbht_ram.sv
`default_nettype none

module hbht_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/core/hbht_cmp.sv
`default_nettype none

module hbht_cmp (
    input  wire hbht_pkg::entry_t         entry,
    input  wire logic [63:0]              key_height,
    input  wire logic [63:0]              key_amount,
    output hbht_pkg::cmp_res_t            res
);

    import hbht_pkg::*;

    always_comb begin
        res.lt     = entry.height < key_height;
        res.eq     = entry.height == key_height;
        res.le     = res.lt | res.eq;
        res.amt_ge = entry.amount >= key_amount;
        res.amt_eq = entry.amount == key_amount;
    end

endmodule

`default_nettype wire

>>> rtl/core/height_balance_history_table_core.sv
// Channel | Handshake          | Payload
// request | s_tvalid, s_tready | s_tuser: mode; s_tdata: height, amount
// result  | m_tvalid, m_tready | m_tdata: balances, count, flags, listed height; m_tlast: last
// One request is handled at a time; s_tready is high only while idle.
// Lookup, list, add and prune each read the stored entries one at a time;
// an add or prune also moves entries one at a time when the table must shift.
// The single read port of the entry memory and the one compare unit set this order.
// Reset empties the table at once; the memory itself is not cleared.
// A stalled result holds the block until it is taken.
`default_nettype none

module height_balance_history_table_core #(
    parameter int TABLE_DEPTH = 32
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // Bits from low: height[63:0], amount[127:64].
    input  wire logic [hbht_pkg::S_TDATA_W-1:0] s_tdata,
    // Bits from low: mode[1:0].
    input  wire logic [hbht_pkg::MODE_W-1:0]    s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // Bits from low: balance_at_height[63:0], latest_balance[127:64],
    // entry_count[133:128], any_at_least[134], full_error[135], listed_height[199:136].
    output logic [hbht_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tlast
);

    import hbht_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic pend_reg, pend_next;
    logic wpend_reg, wpend_next;

    mode_t req_mode_reg, req_mode_next;
    logic [63:0] req_height_reg, req_height_next;
    logic [63:0] req_amount_reg, req_amount_next;

    logic [CW-1:0] iss_reg, iss_next;
    logic [CW-1:0] lt_cnt_reg, lt_cnt_next;
    logic [CW-1:0] le_cnt_reg, le_cnt_next;
    logic below_eq_reg, below_eq_next;
    logic [63:0] le_amt_reg, le_amt_next;
    logic seen_ge_reg, seen_ge_next;
    logic ge_eq_reg, ge_eq_next;
    logic ge_eq_b_reg, ge_eq_b_next;
    logic seen_ge2_reg, seen_ge2_next;
    logic ge2_eq_b_reg, ge2_eq_b_next;
    logic seen_gt_reg, seen_gt_next;
    logic [63:0] gt_amt_reg, gt_amt_next;

    logic [CW-1:0] put_idx_reg, put_idx_next;
    logic put_en_reg, put_en_next;
    logic [63:0] put_amt_reg, put_amt_next;
    logic [CW-1:0] new_cnt_reg, new_cnt_next;
    logic [CW-1:0] mv_src_reg, mv_src_next;
    logic [CW-1:0] mv_left_reg, mv_left_next;
    logic [CW-1:0] mv_d_reg, mv_d_next;
    logic mv_desc_reg, mv_desc_next;
    logic [CW-1:0] wa_reg, wa_next;

    logic [63:0] bal_reg, bal_next;
    logic [63:0] latest_reg, latest_next;
    logic any_reg, any_next;
    logic dropped_reg, dropped_next;
    logic [63:0] listed_reg, listed_next;
    logic last_reg, last_next;
    logic [CW-1:0] lidx_reg, lidx_next;

    logic ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    entry_t ram_wdata;
    entry_t ram_rdata;
    cmp_res_t res;

    hbht_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    hbht_cmp u_cmp (
        .entry      (ram_rdata),
        .key_height (req_height_reg),
        .key_amount (req_amount_reg),
        .res        (res)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_RESP) || (state_reg == ST_LWAIT);
    assign m_tlast  = last_reg;
    assign m_tdata  = {listed_reg, dropped_reg, any_reg, ENTRY_COUNT_W'(cnt_reg),
                       latest_reg, bal_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            wpend_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            wpend_reg <= wpend_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_mode_reg   <= req_mode_next;
        req_height_reg <= req_height_next;
        req_amount_reg <= req_amount_next;
        iss_reg        <= iss_next;
        lt_cnt_reg     <= lt_cnt_next;
        le_cnt_reg     <= le_cnt_next;
        below_eq_reg   <= below_eq_next;
        le_amt_reg     <= le_amt_next;
        seen_ge_reg    <= seen_ge_next;
        ge_eq_reg      <= ge_eq_next;
        ge_eq_b_reg    <= ge_eq_b_next;
        seen_ge2_reg   <= seen_ge2_next;
        ge2_eq_b_reg   <= ge2_eq_b_next;
        seen_gt_reg    <= seen_gt_next;
        gt_amt_reg     <= gt_amt_next;
        put_idx_reg    <= put_idx_next;
        put_en_reg     <= put_en_next;
        put_amt_reg    <= put_amt_next;
        new_cnt_reg    <= new_cnt_next;
        mv_src_reg     <= mv_src_next;
        mv_left_reg    <= mv_left_next;
        mv_d_reg       <= mv_d_next;
        mv_desc_reg    <= mv_desc_next;
        wa_reg         <= wa_next;
        bal_reg        <= bal_next;
        latest_reg     <= latest_next;
        any_reg        <= any_next;
        dropped_reg    <= dropped_next;
        listed_reg     <= listed_next;
        last_reg       <= last_next;
        lidx_reg       <= lidx_next;
    end

    always_comb begin
        logic below_is_b;
        logic dec_exists;
        logic dec_r0;
        logic dec_r1;
        logic dec_k;
        logic dec_skip;
        logic [CW-1:0] dec_i;
        logic [CW-1:0] dec_j;
        logic [CW-1:0] dec_ik;
        logic [63:0] dec_val;
        logic scan_done;

        state_next      = state_reg;
        cnt_next        = cnt_reg;
        pend_next       = 1'b0;
        wpend_next      = 1'b0;
        req_mode_next   = req_mode_reg;
        req_height_next = req_height_reg;
        req_amount_next = req_amount_reg;
        iss_next        = iss_reg;
        lt_cnt_next     = lt_cnt_reg;
        le_cnt_next     = le_cnt_reg;
        below_eq_next   = below_eq_reg;
        le_amt_next     = le_amt_reg;
        seen_ge_next    = seen_ge_reg;
        ge_eq_next      = ge_eq_reg;
        ge_eq_b_next    = ge_eq_b_reg;
        seen_ge2_next   = seen_ge2_reg;
        ge2_eq_b_next   = ge2_eq_b_reg;
        seen_gt_next    = seen_gt_reg;
        gt_amt_next     = gt_amt_reg;
        put_idx_next    = put_idx_reg;
        put_en_next     = put_en_reg;
        put_amt_next    = put_amt_reg;
        new_cnt_next    = new_cnt_reg;
        mv_src_next     = mv_src_reg;
        mv_left_next    = mv_left_reg;
        mv_d_next       = mv_d_reg;
        mv_desc_next    = mv_desc_reg;
        wa_next         = wa_reg;
        bal_next        = bal_reg;
        latest_next     = latest_reg;
        any_next        = any_reg;
        dropped_next    = dropped_reg;
        listed_next     = listed_reg;
        last_next       = last_reg;
        lidx_next       = lidx_reg;
        ram_we          = 1'b0;
        ram_waddr       = put_idx_reg[AW-1:0];
        ram_wdata       = '{height: req_height_reg, amount: put_amt_reg};
        ram_raddr       = iss_reg[AW-1:0];

        // The region below the new height reads as zero when nothing lies below it.
        below_is_b = (lt_cnt_reg != '0) ? below_eq_reg : (req_amount_reg == '0);
        dec_exists = seen_ge_reg && ge_eq_reg;
        if (req_mode_reg == MODE_PRUNE) begin
            dec_i    = '0;
            dec_val  = le_amt_reg;
            dec_r0   = (le_amt_reg == '0);
            dec_r1   = seen_gt_reg && (gt_amt_reg == le_amt_reg);
            dec_j    = le_cnt_reg + CW'(dec_r1);
            dec_skip = (le_cnt_reg == '0);
        end else begin
            dec_i   = lt_cnt_reg;
            dec_val = req_amount_reg;
            dec_r0  = below_is_b;
            if (dec_exists) begin
                dec_r1 = seen_ge2_reg && ge2_eq_b_reg;
                dec_j  = lt_cnt_reg + CW'(1) + CW'(dec_r1);
            end else begin
                dec_r1 = seen_ge_reg && ge_eq_b_reg;
                dec_j  = lt_cnt_reg + CW'(dec_r1);
            end
            dec_skip = !dec_exists && (cnt_reg == DEPTH_C);
        end
        dec_k  = !dec_r0;
        dec_ik = dec_i + CW'(dec_k);

        scan_done = (iss_reg == cnt_reg) && !pend_reg;
        if ((state_reg == ST_SCAN || state_reg == ST_STAT) && iss_reg != cnt_reg) begin
            iss_next  = iss_reg + CW'(1);
            pend_next = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    req_mode_next   = mode_t'(s_tuser);
                    req_height_next = s_tdata[63:0];
                    req_amount_next = s_tdata[127:64];
                    iss_next        = '0;
                    lt_cnt_next     = '0;
                    le_cnt_next     = '0;
                    seen_ge_next    = 1'b0;
                    seen_ge2_next   = 1'b0;
                    seen_gt_next    = 1'b0;
                    bal_next        = '0;
                    latest_next     = '0;
                    any_next        = 1'b0;
                    dropped_next    = 1'b0;
                    if (mode_t'(s_tuser) == MODE_ADD || mode_t'(s_tuser) == MODE_PRUNE) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_STAT;
                    end
                end
            end
            ST_SCAN: begin
                if (pend_reg) begin
                    if (res.lt) begin
                        lt_cnt_next   = lt_cnt_reg + CW'(1);
                        below_eq_next = res.amt_eq;
                    end
                    if (res.le) begin
                        le_cnt_next = le_cnt_reg + CW'(1);
                        le_amt_next = ram_rdata.amount;
                    end
                    if (!res.lt && !seen_ge_reg) begin
                        seen_ge_next = 1'b1;
                        ge_eq_next   = res.eq;
                        ge_eq_b_next = res.amt_eq;
                    end else if (seen_ge_reg && !seen_ge2_reg) begin
                        seen_ge2_next = 1'b1;
                        ge2_eq_b_next = res.amt_eq;
                    end
                    if (!res.le && !seen_gt_reg) begin
                        seen_gt_next = 1'b1;
                        gt_amt_next  = ram_rdata.amount;
                    end
                end
                if (scan_done) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (dec_skip) begin
                    dropped_next = (req_mode_reg == MODE_ADD);
                    iss_next     = '0;
                    state_next   = ST_STAT;
                end else begin
                    put_idx_next = dec_i;
                    put_en_next  = dec_k;
                    put_amt_next = dec_val;
                    new_cnt_next = dec_ik + (cnt_reg - dec_j);
                    mv_left_next = cnt_reg - dec_j;
                    if (dec_j < dec_ik) begin
                        mv_desc_next = 1'b1;
                        mv_src_next  = cnt_reg - CW'(1);
                    end else begin
                        mv_desc_next = 1'b0;
                        mv_src_next  = dec_j;
                    end
                    mv_d_next = dec_j - dec_ik;
                    if (dec_j != cnt_reg && dec_j != dec_ik) begin
                        state_next = ST_MOVE;
                    end else begin
                        state_next = ST_PUT;
                    end
                end
            end
            ST_MOVE: begin
                ram_raddr = mv_src_reg[AW-1:0];
                if (mv_left_reg != '0) begin
                    mv_left_next = mv_left_reg - CW'(1);
                    wpend_next   = 1'b1;
                    if (mv_desc_reg) begin
                        mv_src_next = mv_src_reg - CW'(1);
                        wa_next     = mv_src_reg + CW'(1);
                    end else begin
                        mv_src_next = mv_src_reg + CW'(1);
                        wa_next     = mv_src_reg - mv_d_reg;
                    end
                end
                if (wpend_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = wa_reg[AW-1:0];
                    ram_wdata = ram_rdata;
                end
                if (mv_left_reg == '0 && !wpend_reg) begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT: begin
                ram_we     = put_en_reg;
                cnt_next   = new_cnt_reg;
                iss_next   = '0;
                state_next = ST_STAT;
            end
            ST_STAT: begin
                if (pend_reg) begin
                    if (res.le) begin
                        bal_next = ram_rdata.amount;
                    end
                    latest_next = ram_rdata.amount;
                    if (res.amt_ge) begin
                        any_next = 1'b1;
                    end
                end
                if (scan_done) begin
                    if (req_mode_reg == MODE_LIST && cnt_reg != '0) begin
                        lidx_next  = '0;
                        state_next = ST_LREAD;
                    end else begin
                        listed_next = '0;
                        last_next   = 1'b1;
                        state_next  = ST_RESP;
                    end
                end
            end
            ST_RESP: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            ST_LREAD: begin
                ram_raddr  = lidx_reg[AW-1:0];
                state_next = ST_LLOAD;
            end
            ST_LLOAD: begin
                listed_next = ram_rdata.height;
                last_next   = (lidx_reg + CW'(1) == cnt_reg);
                state_next  = ST_LWAIT;
            end
            ST_LWAIT: begin
                if (m_tready) begin
                    if (last_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        lidx_next  = lidx_reg + CW'(1);
                        state_next = ST_LREAD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= DEPTH_C)
        else $error("Entry count exceeds the table depth.");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("Request accepted while another is in progress.");

    a_idle_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("Block did not return to idle after the final result.");

    a_no_result_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid)
        else $error("Result offered while idle.");

    a_full_only_on_add: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && dropped_reg) |-> (req_mode_reg == MODE_ADD))
        else $error("Full flag raised on a request that is not an add.");

endmodule

`default_nettype wire

>>> verif/height_balance_history_table_core_test.sv
module height_balance_history_table_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hbht_pkg::*;

    localparam int TABLE_DEPTH = 32;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_REQUESTS = 480;
    localparam logic [63:0] TOP = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic [63:0] balance;
        logic [63:0] latest;
        logic [5:0]  count;
        logic        any_ge;
        logic        full_drop;
        logic [63:0] listed;
        logic        last;
    } balance_result_t;

    class balance_history_board;
        logic [63:0] heights[TABLE_DEPTH];
        logic [63:0] amounts[TABLE_DEPTH];
        int unsigned used;
        balance_result_t pending_results[$];
        int failures;

        function int unsigned entries_at_or_below(logic [63:0] h);
            int unsigned n = 0;
            while (n < used && heights[n] <= h) n++;
            return n;
        endfunction

        function logic [63:0] step_balance(logic [63:0] h);
            int unsigned n;
            n = entries_at_or_below(h);
            return (n != 0) ? amounts[n-1] : 64'd0;
        endfunction

        function void drop_entry(int unsigned i);
            int unsigned k;
            for (k = i; k + 1 < used; k++) begin
                heights[k] = heights[k+1];
                amounts[k] = amounts[k+1];
            end
            used--;
        endfunction

        // Returns 1 when a new height is refused because the table is full.
        function bit insert_amount(logic [63:0] h, logic [63:0] b);
            int unsigned i = 0;
            int unsigned k;
            logic [63:0] below;
            while (i < used && heights[i] < h) i++;
            if (i < used && heights[i] == h) begin
                amounts[i] = b;
            end else begin
                if (used >= TABLE_DEPTH) return 1'b1;
                for (k = used; k > i; k--) begin
                    heights[k] = heights[k-1];
                    amounts[k] = amounts[k-1];
                end
                heights[i] = h;
                amounts[i] = b;
                used++;
            end
            if (i + 1 < used && amounts[i+1] == b) drop_entry(i + 1);
            below = (h != 0) ? step_balance(h - 64'd1) : 64'd0;
            if (below == b) drop_entry(i);
            return 1'b0;
        endfunction

        function void fold_below(logic [63:0] h);
            int unsigned n, k;
            logic [63:0] bal;
            n = entries_at_or_below(h);
            if (n == 0) return;
            bal = amounts[n-1];
            for (k = 0; k + n < used; k++) begin
                heights[k] = heights[k+n];
                amounts[k] = amounts[k+n];
            end
            used -= n;
            void'(insert_amount(h, bal));
        endfunction

        function void apply_request(mode_t mode, logic [63:0] h, logic [63:0] a);
            balance_result_t r;
            int unsigned k, nres;
            r.full_drop = 1'b0;
            case (mode)
                MODE_ADD:   r.full_drop = insert_amount(h, a);
                MODE_PRUNE: fold_below(h);
                default: ;
            endcase
            r.balance = step_balance(h);
            r.latest = (used != 0) ? amounts[used-1] : 64'd0;
            r.count = used[5:0];
            r.any_ge = 1'b0;
            for (k = 0; k < used; k++)
                if (amounts[k] >= a) r.any_ge = 1'b1;
            nres = (mode == MODE_LIST && used != 0) ? used : 1;
            for (k = 0; k < nres; k++) begin
                r.listed = (mode == MODE_LIST && used != 0) ? heights[k] : 64'd0;
                r.last = (k + 1 == nres);
                pending_results = {pending_results, r};
            end
        endfunction

        function void match_field(string name, logic [63:0] exp, logic [63:0] act);
            if (act !== exp) begin
                $error("%s: expected %0h, got %0h", name, exp, act);
                failures++;
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data, logic tlast);
            balance_result_t e;
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: data %0h", data);
                failures++;
                return;
            end
            e = pending_results.pop_front();
            match_field("balance_at_height", e.balance, data[63:0]);
            match_field("latest_balance", e.latest, data[127:64]);
            match_field("entry_count", 64'(e.count), 64'(data[133:128]));
            match_field("any_at_least", 64'(e.any_ge), 64'(data[134]));
            match_field("full_error", 64'(e.full_drop), 64'(data[135]));
            match_field("listed_height", e.listed, data[199:136]);
            match_field("last", 64'(e.last), 64'(tlast));
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [MODE_W-1:0]    s_tuser = MODE_LOOKUP;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    balance_history_board board = new();
    int  cycles = 0;
    int  requests_sent = 0;
    int  hold_requests = 0;
    int  holds_served = 0;
    int  stall_left = 0;
    bit  no_idle = 1'b0;

    height_balance_history_table_core #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: random back-pressure plus one long hold-off on request.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_result(m_tdata, m_tlast);
        if (hold_requests != holds_served) begin
            holds_served++;
            stall_left = HOLD_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= no_idle || ($urandom_range(0, 99) >= 15);
        end
    end

    task automatic send_request(mode_t mode, logic [63:0] h, logic [63:0] a);
        if (!no_idle) begin
            while ($urandom_range(0, 99) < 15) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata <= {a, h};
        s_tuser <= mode;
        do @(posedge aclk); while (!s_tready);
        board.apply_request(mode, h, a);
        requests_sent++;
    endtask

    function automatic logic [63:0] pick_height(bit wide);
        logic [63:0] h;
        h = wide ? {$urandom, $urandom} : 64'($urandom_range(1, 48));
        if (h == 0) h = 64'd1;
        return h;
    endfunction

    function automatic logic [63:0] pick_amount(bit wide);
        return wide ? {$urandom, $urandom} : 64'($urandom_range(0, 4));
    endfunction

    function automatic mode_t pick_mode();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) return MODE_ADD;
        if (r < 55) return MODE_PRUNE;
        if (r < 85) return MODE_LOOKUP;
        return MODE_LIST;
    endfunction

    // Builds a full table of strictly rising amounts, then pushes past capacity.
    task automatic fill_table();
        logic [63:0] h, a;
        int i;
        send_request(MODE_PRUNE, TOP, pick_amount(0));
        h = 64'($urandom_range(1, 8));
        a = pick_amount(0);
        for (i = 0; i < 36; i++) begin
            a = a + 64'($urandom_range(1, 9));
            send_request(MODE_ADD, h, a);
            h = h + 64'($urandom_range(1, 3));
            if ($urandom_range(0, 7) == 0)
                send_request(MODE_LOOKUP, 64'($urandom_range(1, 130)), pick_amount(1));
        end
        for (i = 0; i < 6; i++)
            send_request(MODE_ADD, 64'($urandom_range(1, 130)), {$urandom, $urandom});
        send_request(MODE_LIST, pick_height(0), pick_amount(0));
        if ($urandom_range(0, 1) == 1)
            send_request(MODE_PRUNE, 64'($urandom_range(1, 130)), pick_amount(0));
    endtask

    initial begin
        bit hold_done = 1'b0;
        bit drain_done = 1'b0;
        int i, kind;
        bit wide;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        send_request(MODE_LOOKUP, 64'd1, 64'd0);
        send_request(MODE_LIST, 64'd1, 64'd0);
        send_request(MODE_ADD, TOP, TOP);
        send_request(MODE_ADD, 64'd1, 64'd0);
        send_request(MODE_ADD, 64'd10, 64'd5);
        send_request(MODE_ADD, 64'd20, 64'd5);
        send_request(MODE_ADD, 64'd5, 64'd5);
        send_request(MODE_ADD, 64'd5, 64'd9);
        send_request(MODE_ADD, 64'd30, 64'd3);
        send_request(MODE_LOOKUP, 64'd29, 64'd9);
        send_request(MODE_LOOKUP, 64'd4, TOP);
        send_request(MODE_PRUNE, 64'd2, 64'd0);
        send_request(MODE_PRUNE, 64'd30, 64'd1);
        send_request(MODE_LIST, 64'd30, 64'd4);
        send_request(MODE_PRUNE, TOP, 64'd0);
        send_request(MODE_ADD, TOP - 64'd1, 64'd0);
        send_request(MODE_LIST, TOP, 64'hAAAA_AAAA_AAAA_AAAA);
        send_request(MODE_ADD, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        send_request(MODE_LOOKUP, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        send_request(MODE_LOOKUP, TOP, 64'd0);
        send_request(MODE_LIST, 64'd1, TOP);

        while (requests_sent < RANDOM_REQUESTS) begin
            if (!hold_done && requests_sent >= 150) begin
                hold_done = 1'b1;
                hold_requests++;
            end
            if (!drain_done && requests_sent >= 320) begin
                drain_done = 1'b1;
                s_tvalid <= 1'b0;
                while (board.pending_results.size() != 0) @(posedge aclk);
            end
            no_idle = (requests_sent >= 220 && requests_sent < 300);
            kind = $urandom_range(0, 9);
            if (kind < 3) begin
                fill_table();
            end else if (kind < 8) begin
                for (i = 0; i < 20; i++) begin
                    wide = ($urandom_range(0, 9) == 0);
                    send_request(pick_mode(), pick_height(wide), pick_amount(wide));
                end
            end else begin
                for (i = 0; i < 10; i++)
                    send_request(mode_t'($urandom_range(0, 3)), pick_height(1), pick_amount(1));
            end
        end
        no_idle = 1'b0;

        s_tvalid <= 1'b0;
        while (board.pending_results.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (board.failures == 0 && board.pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
